[rtl/assert_macros.svh]
// Assertion macros shared by the checker modules of this block.
// Each macro samples on the rising edge of clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds in the same cycle.
`define TRC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons holds in the cycle after.
`define TRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/trc_pkg.sv]
`default_nettype none

package trc_pkg;

    localparam int COORD_W   = 6;
    localparam int FB_W      = 8;
    localparam int MIP_W     = 4;
    localparam int KIND_W    = 2;
    localparam int LVL_OUT_W = 3;
    localparam int RC_W      = 13;
    localparam int ADDR_W    = 20;
    localparam int TWIDTH_W  = 9;

    localparam logic [RC_W-1:0]  RC_MAX        = 13'd8191;
    localparam logic [MIP_W-1:0] MAX_MIP_RESET = 4'd8;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ADJUST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EVICT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNCH   = 2'd3;

    typedef struct packed {
        logic clear;
        logic load_in;
        logic decide;
        logic addr_ld;
        logic rd;
        logic upd;
        logic emit_unch;
    } trc_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic oob;
        logic same;
        logic last;
        logic out_free;
    } trc_status_t;

    // Number of tiles along one dimension at a given mip level.
    function automatic int unsigned lvl_width(input int unsigned dim, input int unsigned s);
        return ((dim - 1) >> s) + 1;
    endfunction

    // Offset of the first tile of a mip level in the refcount store.
    function automatic int unsigned lvl_base(input int unsigned cols, input int unsigned rows,
                                             input int unsigned s);
        int unsigned acc;
        acc = 0;
        for (int unsigned k = 0; k < s; k++)
        begin
            acc += lvl_width(cols, k) * lvl_width(rows, k);
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

[rtl/trc_ctrl.sv]
`default_nettype none

module trc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire trc_pkg::trc_status_t status,
    output trc_pkg::trc_cmd_t        cmd
);
    import trc_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_UNCH   = 3'd3;
    localparam logic [2:0] S_ADDR   = 3'd4;
    localparam logic [2:0] S_RD     = 3'd5;
    localparam logic [2:0] S_UPD    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = (status.oob || status.same) ? S_UNCH : S_ADDR;
            end
            S_UNCH:
            begin
                if (status.out_free)
                begin
                    cmd.emit_unch = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_ADDR:
            begin
                cmd.addr_ld = 1'b1;
                state_next  = S_RD;
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (status.out_free)
                begin
                    cmd.upd    = 1'b1;
                    state_next = status.last ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/trc_dp.sv]
`default_nettype none

module trc_dp #(
    parameter int REGION_COLS = 64,
    parameter int REGION_ROWS = 64,
    parameter int MIP_LEVELS  = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [trc_pkg::MIP_W-1:0]       cfg_max_mip,
    input  wire logic [trc_pkg::COORD_W-1:0]     region_x,
    input  wire logic [trc_pkg::COORD_W-1:0]     region_y,
    input  wire logic [trc_pkg::FB_W-1:0]        feedback_mip,
    input  wire trc_pkg::trc_cmd_t               cmd,
    output trc_pkg::trc_status_t                 status,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic [trc_pkg::KIND_W-1:0]           kind,
    output logic [trc_pkg::COORD_W-1:0]          tile_x,
    output logic [trc_pkg::COORD_W-1:0]          tile_y,
    output logic [trc_pkg::LVL_OUT_W-1:0]        mip_level,
    output logic                                 last
);
    import trc_pkg::*;

    localparam int REGION_DEPTH = REGION_COLS * REGION_ROWS;
    localparam int TILE_DEPTH   = 2 * REGION_COLS * REGION_ROWS
                                  + 2 * (REGION_COLS + REGION_ROWS) + MIP_LEVELS;
    localparam int RAW          = (REGION_DEPTH > 1) ? $clog2(REGION_DEPTH) : 1;
    localparam int TAW          = $clog2(TILE_DEPTH);
    localparam int LIDX_W       = (MIP_LEVELS > 1) ? $clog2(MIP_LEVELS) : 1;
    localparam int LVL_N        = 2 ** LIDX_W;

    localparam logic [TAW-1:0]    CLR_LAST     = TAW'(TILE_DEPTH - 1);
    localparam logic [TAW-1:0]    REGION_END   = TAW'(REGION_DEPTH);
    localparam logic [MIP_W-1:0]  ML_C         = MIP_W'(MIP_LEVELS);
    localparam logic [ADDR_W-1:0] COLS_C       = ADDR_W'(REGION_COLS);
    localparam logic [ADDR_W-1:0] ROWS_C       = ADDR_W'(REGION_ROWS);

    // Per-level constants: first tile of the level and tiles per row.
    logic [TAW-1:0]      base_tab  [LVL_N];
    logic [TWIDTH_W-1:0] width_tab [LVL_N];

    for (genvar g = 0; g < LVL_N; g++)
    begin : g_lvl
        assign base_tab[g]  = TAW'(lvl_base(REGION_COLS, REGION_ROWS, g));
        assign width_tab[g] = TWIDTH_W'(lvl_width(REGION_COLS, g));
    end

    // Storage.
    logic [MIP_W-1:0] region_mem [REGION_DEPTH];
    logic [RC_W-1:0]  tile_mem   [TILE_DEPTH];

    // Control registers.
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [MIP_W-1:0] max_mip_reg;
    logic [MIP_W-1:0] max_mip_next;
    logic [TAW-1:0]   clr_cnt_reg;
    logic [TAW-1:0]   clr_cnt_next;

    // Item registers.
    logic [COORD_W-1:0]   rx_reg;
    logic [COORD_W-1:0]   ry_reg;
    logic [FB_W-1:0]      fb_reg;
    logic [RAW-1:0]       ridx_reg;
    logic [MIP_W-1:0]     region_rd_reg;
    logic                 oob_reg;
    logic                 down_reg;
    logic [MIP_W-1:0]     desired_reg;
    logic [MIP_W-1:0]     level_reg;
    logic [TAW-1:0]       addr_reg;
    logic [RC_W-1:0]      rc_rd_reg;

    // Output registers.
    logic [KIND_W-1:0]    kind_reg;
    logic [COORD_W-1:0]   tile_x_reg;
    logic [COORD_W-1:0]   tile_y_reg;
    logic [LVL_OUT_W-1:0] mip_level_reg;
    logic                 last_reg;

    // Combinational signals.
    logic [ADDR_W-1:0]    ridx_full;
    logic [RAW-1:0]       ridx_in;
    logic                 oob;
    logic [MIP_W-1:0]     lim;
    logic [MIP_W-1:0]     desired;
    logic [MIP_W-1:0]     cur;
    logic                 same;
    logic                 down;
    logic [MIP_W-1:0]     start_level;
    logic [MIP_W-1:0]     level_step;
    logic [MIP_W-1:0]     lvl_src;
    logic [LIDX_W-1:0]    lvl_idx;
    logic [COORD_W-1:0]   tx_src;
    logic [COORD_W-1:0]   ty_src;
    logic [ADDR_W-1:0]    addr_full;
    logic                 last_now;
    logic [KIND_W-1:0]    upd_kind;
    logic [RC_W-1:0]      rc_new;
    logic                 region_we;
    logic [RAW-1:0]       region_wa;
    logic [MIP_W-1:0]     region_wd;
    logic                 tile_we;
    logic [TAW-1:0]       tile_wa;
    logic [RC_W-1:0]      tile_wd;

    assign ridx_full = ADDR_W'(region_y) * COLS_C + ADDR_W'(region_x);
    assign ridx_in   = RAW'(ridx_full);

    // Decision on the region's stored mip, valid in the cycle after the item is taken.
    assign oob         = (ADDR_W'(rx_reg) >= COLS_C) || (ADDR_W'(ry_reg) >= ROWS_C);
    assign lim         = (max_mip_reg > ML_C) ? ML_C : max_mip_reg;
    assign desired     = (fb_reg < FB_W'(lim)) ? MIP_W'(fb_reg) : lim;
    assign cur         = (region_rd_reg > ML_C) ? ML_C : region_rd_reg;
    assign same        = (desired == cur);
    assign down        = (desired < cur);
    assign start_level = down ? (cur - 4'd1) : cur;

    assign level_step = down_reg ? (level_reg - 4'd1) : (level_reg + 4'd1);
    assign last_now   = down_reg ? (level_reg == desired_reg)
                                 : ((level_reg + 4'd1) == desired_reg);

    // Tile address of a level: base + row * tiles_per_row + column.
    assign lvl_src   = cmd.upd ? level_step : level_reg;
    assign lvl_idx   = LIDX_W'(lvl_src);
    assign tx_src    = rx_reg >> lvl_src;
    assign ty_src    = ry_reg >> lvl_src;
    assign addr_full = ADDR_W'(base_tab[lvl_idx])
                       + ADDR_W'(ty_src) * ADDR_W'(width_tab[lvl_idx])
                       + ADDR_W'(tx_src);

    always_comb
    begin
        if (down_reg)
        begin
            upd_kind = (rc_rd_reg == '0) ? KIND_LOAD : KIND_ADJUST;
            rc_new   = (rc_rd_reg != RC_MAX) ? (rc_rd_reg + 13'd1) : rc_rd_reg;
        end
        else
        begin
            upd_kind = (rc_rd_reg == 13'd1) ? KIND_EVICT : KIND_ADJUST;
            rc_new   = (rc_rd_reg != '0) ? (rc_rd_reg - 13'd1) : rc_rd_reg;
        end
    end

    // Memory write ports: the clearing sweep after reset, then normal updates.
    assign region_we = (cmd.clear && (clr_cnt_reg < REGION_END))
                       || (cmd.upd && last_now)
                       || (cmd.emit_unch && !oob_reg);
    assign region_wa = cmd.clear ? RAW'(clr_cnt_reg) : ridx_reg;
    assign region_wd = cmd.clear ? MAX_MIP_RESET : desired_reg;

    assign tile_we = cmd.clear || cmd.upd;
    assign tile_wa = cmd.clear ? clr_cnt_reg : addr_reg;
    assign tile_wd = cmd.clear ? '0 : rc_new;

    always_ff @(posedge clk)
    begin
        if (region_we)
        begin
            region_mem[region_wa] <= region_wd;
        end
        if (cmd.load_in)
        begin
            region_rd_reg <= region_mem[ridx_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tile_we)
        begin
            tile_mem[tile_wa] <= tile_wd;
        end
        if (cmd.rd)
        begin
            rc_rd_reg <= tile_mem[addr_reg];
        end
    end

    always_comb
    begin
        max_mip_next = cfg_we ? cfg_max_mip : max_mip_reg;
        clr_cnt_next = (cmd.clear && (clr_cnt_reg != CLR_LAST))
                       ? (clr_cnt_reg + TAW'(1)) : clr_cnt_reg;
        if (cmd.upd || cmd.emit_unch)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            max_mip_reg   <= MAX_MIP_RESET;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            max_mip_reg   <= max_mip_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            rx_reg   <= region_x;
            ry_reg   <= region_y;
            fb_reg   <= feedback_mip;
            ridx_reg <= ridx_in;
        end
        if (cmd.decide)
        begin
            oob_reg     <= oob;
            down_reg    <= down;
            desired_reg <= desired;
            level_reg   <= start_level;
        end
        else if (cmd.upd)
        begin
            level_reg <= level_step;
        end
        if (cmd.addr_ld || cmd.upd)
        begin
            addr_reg <= TAW'(addr_full);
        end
        if (cmd.upd)
        begin
            kind_reg      <= upd_kind;
            tile_x_reg    <= rx_reg >> level_reg;
            tile_y_reg    <= ry_reg >> level_reg;
            mip_level_reg <= LVL_OUT_W'(level_reg);
            last_reg      <= last_now;
        end
        else if (cmd.emit_unch)
        begin
            kind_reg      <= KIND_UNCH;
            tile_x_reg    <= rx_reg;
            tile_y_reg    <= ry_reg;
            mip_level_reg <= '0;
            last_reg      <= 1'b1;
        end
    end

    assign status.clear_done = (clr_cnt_reg == CLR_LAST);
    assign status.oob        = oob;
    assign status.same       = same;
    assign status.last       = last_now;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign tile_x    = tile_x_reg;
    assign tile_y    = tile_y_reg;
    assign mip_level = mip_level_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

[rtl/tile_refcount_update.sv]
// Tile reference-count updater for streamed, mipmapped textures.
// Input channel (in_valid/in_ready): one feedback entry per transfer, giving a
// region and a raw desired mip. Output channel (out_valid/out_ready): one
// transfer per touched mip level, or a single "unchanged" result; the final
// result of an entry carries last. Configuration channel (cfg_valid/cfg_ready,
// data max_mip) is always ready and is to be written only while the block idles.
// After reset the block sweeps both stores, one entry a cycle, with in_ready
// low, across the 2*REGION_COLS*REGION_ROWS + 2*(REGION_COLS+REGION_ROWS) +
// MIP_LEVELS refcount entries (8456 at the default sizes); max_mip returns to 8.
// One entry is worked on at a time. Each entry passes a decide state; an unchanged
// entry then passes the unchanged state, where its result is registered. An entry
// that touches levels passes an address state and then, per touched level, a read
// state with a registered read of the refcount store and an update state that
// writes the new count and registers the result. A result sits in an output
// register, so a stalled receiver holds the block only when the next result is
// ready to be written; it then waits without losing data.
`default_nettype none

module tile_refcount_update #(
    parameter int REGION_COLS = 64,
    parameter int REGION_ROWS = 64,
    parameter int MIP_LEVELS  = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [trc_pkg::MIP_W-1:0]        max_mip,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [trc_pkg::COORD_W-1:0]      region_x,
    input  wire logic [trc_pkg::COORD_W-1:0]      region_y,
    input  wire logic [trc_pkg::FB_W-1:0]         feedback_mip,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [trc_pkg::KIND_W-1:0]            kind,
    output logic [trc_pkg::COORD_W-1:0]           tile_x,
    output logic [trc_pkg::COORD_W-1:0]           tile_y,
    output logic [trc_pkg::LVL_OUT_W-1:0]         mip_level,
    output logic                                  last
);
    import trc_pkg::*;

    trc_cmd_t    cmd;
    trc_status_t status;

    // The register is a plain flop, so a write transfer completes at once.
    assign cfg_ready = 1'b1;

    // The controller sequences each entry: decide, then one read and one write
    // of the refcount store for every touched level.
    trc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds both stores, the max_mip register and the output register.
    trc_dp #(
        .REGION_COLS (REGION_COLS),
        .REGION_ROWS (REGION_ROWS),
        .MIP_LEVELS  (MIP_LEVELS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid),
        .cfg_max_mip  (max_mip),
        .region_x     (region_x),
        .region_y     (region_y),
        .feedback_mip (feedback_mip),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .kind         (kind),
        .tile_x       (tile_x),
        .tile_y       (tile_y),
        .mip_level    (mip_level),
        .last         (last)
    );

endmodule

`default_nettype wire

[rtl/trc_chk.sv]
`default_nettype none
`include "assert_macros.svh"

module trc_chk (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic [trc_pkg::KIND_W-1:0]       kind,
    input wire logic [trc_pkg::COORD_W-1:0]      tile_x,
    input wire logic [trc_pkg::COORD_W-1:0]      tile_y,
    input wire logic [trc_pkg::LVL_OUT_W-1:0]    mip_level,
    input wire logic                             last
);
    import trc_pkg::*;

    // A stalled result stays offered.
    `TRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // An entry is worked on alone, so the input closes right after a transfer.
    `TRC_ASSERT_NEXT(a_one_entry, in_valid && in_ready, !in_ready)

    // An unchanged result is the only result of its entry and names level zero.
    `TRC_ASSERT_IMP(a_unch_form, out_valid && (kind == KIND_UNCH), last && (mip_level == '0))

    // A stalled result keeps its payload.
    `TRC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
        $stable(kind) && $stable(tile_x) && $stable(tile_y) && $stable(mip_level) && $stable(last))

endmodule

bind tile_refcount_update trc_chk u_trc_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .tile_x    (tile_x),
    .tile_y    (tile_y),
    .mip_level (mip_level),
    .last      (last)
);

`default_nettype wire

[test/tb_top.sv]
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import trc_pkg::*;

    // Grid sizes as built into the instance below.
    localparam int REGION_COLS = 64;
    localparam int REGION_ROWS = 64;
    localparam int MIP_LEVELS  = 8;

    // The block sweeps its stores after reset, and the output register lets the results of
    // an entry trickle out behind its own work.
    // SETTLE_CYCLES covers the tail of an entry after its final result has been taken.
    localparam int SETTLE_CYCLES = 30;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 1000000;

    // One result transfer as seen on the output channel.
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [COORD_W-1:0]   tile_x;
        logic [COORD_W-1:0]   tile_y;
        logic [LVL_OUT_W-1:0] mip_level;
        logic                 last;
    } tile_touch_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [MIP_W-1:0]     max_mip;
    logic                 in_valid;
    logic                 in_ready;
    logic [COORD_W-1:0]   region_x;
    logic [COORD_W-1:0]   region_y;
    logic [FB_W-1:0]      feedback_mip;
    logic                 out_valid;
    logic                 out_ready;
    logic [KIND_W-1:0]    kind;
    logic [COORD_W-1:0]   tile_x;
    logic [COORD_W-1:0]   tile_y;
    logic [LVL_OUT_W-1:0] mip_level;
    logic                 last;

    tile_refcount_update #(
        .REGION_COLS(REGION_COLS),
        .REGION_ROWS(REGION_ROWS),
        .MIP_LEVELS (MIP_LEVELS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .max_mip     (max_mip),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .region_x    (region_x),
        .region_y    (region_y),
        .feedback_mip(feedback_mip),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .tile_x      (tile_x),
        .tile_y      (tile_y),
        .mip_level   (mip_level),
        .last        (last)
    );

    // Our own copy of the block's state: the stored mip of every region, the refcount of
    // every tile at every level, and the clamp register as last written.
    logic [MIP_W-1:0] region_level [REGION_COLS*REGION_ROWS];
    logic [RC_W-1:0]  tile_count [MIP_LEVELS][REGION_COLS*REGION_ROWS];
    logic [MIP_W-1:0] tracked_mips;

    // Results predicted but not yet seen, oldest at the front.
    tile_touch_t expected_touches [$];

    int  mismatch_count = 0;
    int  cycle_count = 0;

    // Idling switches shared between the test tasks and the driving processes.
    bit  tx_idle_on = 1'b0;
    bit  rx_idle_on = 1'b0;
    bit  long_hold_req = 1'b0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // A hung block must not run for ever: give up well beyond the slowest correct run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Gap length for either side: mostly none or short, now and then a long one.
    function automatic int pick_gap(input bit enabled);
        int unsigned roll;
        if (!enabled)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Add one predicted result at the back of the outstanding list.
    task automatic queue_touch(input tile_touch_t touch);
        expected_touches = {expected_touches, touch};
    endtask

    // Work out what one feedback entry does to the stores and queue the results it gives.
    // A finer desired mip walks down from below the stored level, incrementing; a coarser
    // one walks up from it, decrementing. Equal mips or an outside region give one unchanged result.
    task automatic apply_feedback(input logic [COORD_W-1:0] rx, input logic [COORD_W-1:0] ry,
                                  input logic [FB_W-1:0] fb);
        int          limit;
        int          want;
        int          cur;
        int          lvl;
        int          idx;
        int          slot;
        bit          outside;
        tile_touch_t touch;
        outside = (rx >= REGION_COLS) || (ry >= REGION_ROWS);
        idx = int'(ry) * REGION_COLS + int'(rx);
        want = 0;
        cur = 0;
        if (!outside)
        begin
            limit = (tracked_mips > MIP_LEVELS) ? MIP_LEVELS : int'(tracked_mips);
            want = (fb < limit) ? int'(fb) : limit;
            cur = (region_level[idx] > MIP_LEVELS) ? MIP_LEVELS : int'(region_level[idx]);
        end
        if (outside || want == cur)
        begin
            touch.kind = KIND_UNCH;
            touch.tile_x = rx;
            touch.tile_y = ry;
            touch.mip_level = '0;
            touch.last = 1'b1;
            queue_touch(touch);
        end
        else if (want < cur)
        begin
            for (lvl = cur - 1; lvl >= want; lvl--)
            begin
                touch.tile_x = rx >> lvl;
                touch.tile_y = ry >> lvl;
                slot = int'(touch.tile_y) * REGION_COLS + int'(touch.tile_x);
                touch.kind = (tile_count[lvl][slot] == 0) ? KIND_LOAD : KIND_ADJUST;
                // The count saturates rather than wrapping.
                if (tile_count[lvl][slot] < RC_MAX)
                    tile_count[lvl][slot] = tile_count[lvl][slot] + RC_W'(1);
                touch.mip_level = lvl[LVL_OUT_W-1:0];
                touch.last = (lvl == want);
                queue_touch(touch);
            end
        end
        else
        begin
            for (lvl = cur; lvl < want; lvl++)
            begin
                touch.tile_x = rx >> lvl;
                touch.tile_y = ry >> lvl;
                slot = int'(touch.tile_y) * REGION_COLS + int'(touch.tile_x);
                touch.kind = KIND_ADJUST;
                // An empty count stays at zero and asks for no eviction.
                if (tile_count[lvl][slot] != 0)
                begin
                    if (tile_count[lvl][slot] == 1)
                        touch.kind = KIND_EVICT;
                    tile_count[lvl][slot] = tile_count[lvl][slot] - RC_W'(1);
                end
                touch.mip_level = lvl[LVL_OUT_W-1:0];
                touch.last = (lvl + 1 == want);
                queue_touch(touch);
            end
        end
        if (!outside)
            region_level[idx] = want[MIP_W-1:0];
    endtask

    // Compare the result on the output ports with the oldest one outstanding.
    task automatic check_result();
        tile_touch_t want;
        if (expected_touches.size() == 0)
        begin
            flag_mismatch($sformatf("result kind %0d at (%0d,%0d) level %0d with none due",
                                    kind, tile_x, tile_y, mip_level));
            return;
        end
        want = expected_touches.pop_front();
        if (kind !== want.kind)
            flag_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
        if (tile_x !== want.tile_x)
            flag_mismatch($sformatf("tile_x %0d, expected %0d", tile_x, want.tile_x));
        if (tile_y !== want.tile_y)
            flag_mismatch($sformatf("tile_y %0d, expected %0d", tile_y, want.tile_y));
        if (mip_level !== want.mip_level)
            flag_mismatch($sformatf("mip_level %0d, expected %0d", mip_level, want.mip_level));
        if (last !== want.last)
            flag_mismatch($sformatf("last %0d, expected %0d", last, want.last));
    endtask

    // Everything is observed at the rising edge, where the inputs set up at the falling edge
    // are stable. Each transfer on a channel is dealt with here and only here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                apply_feedback(region_x, region_y, feedback_mip);
            if (cfg_valid && cfg_ready)
                tracked_mips = max_mip;
            if (out_valid && out_ready)
                check_result();
        end
    end

    // The receiver. A long hold is counted down here while the sender carries on, so that
    // the output register fills, the block stops taking entries and in_ready drops.
    initial
    begin
        int hold_left;
        int gap_left;
        hold_left = 0;
        gap_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (gap_left > 0)
            begin
                out_ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                gap_left = pick_gap(rx_idle_on);
            end
        end
    end

    // Offer one entry, after a random gap, and hold it until the transfer. Valid is left
    // high afterwards so that back-to-back entries keep it high without a glitch.
    task automatic send_entry(input logic [COORD_W-1:0] rx, input logic [COORD_W-1:0] ry,
                              input logic [FB_W-1:0] fb);
        int gap;
        gap = pick_gap(tx_idle_on);
        @(negedge clk);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        region_x <= rx;
        region_y <= ry;
        feedback_mip <= fb;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop the input, let every outstanding result drain and the block settle, then write
    // the clamp register. Writes are only made while the block has nothing in hand.
    task automatic write_max_mip(input logic [MIP_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_touches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        max_mip <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // At the reset value of eight mips: a full walk down and back up on one region, sharing
    // of coarse tiles between neighbours, the clamp of large bytes, and alternating bits.
    task automatic test_walks_at_reset();
        send_entry(6'd0, 6'd0, 8'd0);
        send_entry(6'd0, 6'd0, 8'd0);
        send_entry(6'd63, 6'd63, 8'd255);
        send_entry(6'd63, 6'd63, 8'd3);
        send_entry(6'd1, 6'd0, 8'd0);
        send_entry(6'd0, 6'd0, 8'd8);
        send_entry(6'd0, 6'd0, 8'd255);
        send_entry(6'd42, 6'd21, 8'h55);
        send_entry(6'd21, 6'd42, 8'hAA);
        send_entry(6'd42, 6'd21, 8'd4);
        send_entry(6'd63, 6'd63, 8'd7);
        send_entry(6'd1, 6'd0, 8'd128);
    endtask

    // The clamp at its extremes. With zero every entry wants level 0; with fifteen the
    // clamp is held at the number of levels; a setting of one leaves a single level.
    task automatic test_clamp_settings();
        write_max_mip(4'd0);
        send_entry(6'd7, 6'd9, 8'd200);
        send_entry(6'd7, 6'd9, 8'd0);
        send_entry(6'd63, 6'd63, 8'd5);
        write_max_mip(4'd15);
        send_entry(6'd7, 6'd9, 8'd255);
        send_entry(6'd7, 6'd9, 8'd9);
        send_entry(6'd63, 6'd63, 8'd15);
        write_max_mip(4'd1);
        send_entry(6'd7, 6'd9, 8'd0);
        send_entry(6'd7, 6'd9, 8'd3);
        send_entry(6'd20, 6'd40, 8'd1);
        write_max_mip(4'd8);
    endtask

    // Random entries. Most land in a small corner of the grid so that neighbouring regions
    // share coarse tiles and loads, adjustments and evictions all turn up; the desired mip
    // mostly lies in the tracked range so that stored mips swing up and down.
    task automatic test_random_traffic();
        int unsigned      roll;
        logic [MIP_W-1:0] setting;
        logic [COORD_W-1:0] rx;
        logic [COORD_W-1:0] ry;
        logic [FB_W-1:0]  fb;
        for (int phase = 0; phase < 4; phase++)
        begin
            roll = $urandom_range(0, 99);
            if (phase == 0)
                setting = 4'd8;
            else if (roll < 75)
                setting = MIP_W'($urandom_range(1, 8));
            else
                setting = (roll < 88) ? 4'd0 : 4'd15;
            write_max_mip(setting);
            // The first phase runs flat out on both sides.
            tx_idle_on = (phase != 0);
            rx_idle_on = (phase != 0);
            repeat (90)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                begin
                    rx = COORD_W'($urandom_range(0, 7));
                    ry = COORD_W'($urandom_range(0, 7));
                end
                else if (roll < 70)
                begin
                    rx = COORD_W'($urandom_range(60, 63));
                    ry = COORD_W'($urandom_range(60, 63));
                end
                else
                begin
                    rx = COORD_W'($urandom_range(0, 63));
                    ry = COORD_W'($urandom_range(0, 63));
                end
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    fb = FB_W'($urandom_range(0, 9));
                else if (roll < 92)
                    fb = FB_W'($urandom_range(0, 255));
                else
                    fb = 8'hFF;
                send_entry(rx, ry, fb);
            end
        end
    endtask

    // The receiver holds off for a long stretch while full eight-level walks keep coming,
    // so the block has to stall its input and then recover without losing a result.
    task automatic test_output_hold();
        write_max_mip(4'd8);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        long_hold_req = 1'b1;
        for (int n = 0; n < 24; n++)
            send_entry(6'd5, 6'd5, (n % 2 == 0) ? 8'd0 : 8'd8);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        max_mip = '0;
        in_valid = 1'b0;
        region_x = '0;
        region_y = '0;
        feedback_mip = '0;
        tracked_mips = MAX_MIP_RESET;
        foreach (region_level[i])
            region_level[i] = MAX_MIP_RESET;
        foreach (tile_count[l, i])
            tile_count[l][i] = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The first entry waits out the store sweep that follows reset.
        test_walks_at_reset();
        test_clamp_settings();
        test_random_traffic();
        test_output_hold();

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_touches.size() != 0)
            @(posedge clk);
        // Anything the block still sends after this point is flagged by the checker.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
